// ===== rtl/core/clock_sync_pi_loop_macros.svh =====
// Assertion macros for the clock sync PI loop.
`ifndef CLOCK_SYNC_PI_LOOP_MACROS_SVH
`define CLOCK_SYNC_PI_LOOP_MACROS_SVH

// Implication checked every cycle outside reset.
`define CSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define CSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/csp_pkg.sv =====
// Types, constants and helpers for the clock sync PI loop.
package csp_pkg;

  typedef enum logic [1:0] {
    KIND_LOOP   = 2'd0,
    KIND_OFFSET = 2'd1,
    KIND_STEP   = 2'd2
  } kind_e;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_MEAS = 1'b1;

  localparam logic [1:0] REG_STEP_LIMIT = 2'd0;
  localparam logic [1:0] REG_FILTER_B   = 2'd1;
  localparam logic [1:0] REG_FILTER_A   = 2'd2;
  localparam logic [1:0] REG_FILTER_EN  = 2'd3;

  localparam logic [30:0]        STEP_LIMIT_RST = 31'd134217728;
  localparam logic signed [31:0] FILTER_B_RST   = 32'sd1073741824;
  localparam logic signed [31:0] FILTER_A_RST   = 32'sd1073741824;
  localparam logic               FILTER_EN_RST  = 1'b1;

  // Divisors 4, 8 and 512 as shifts
  localparam int unsigned KD_SHIFT = 2;
  localparam int unsigned KP_SHIFT = 3;
  localparam int unsigned KI_SHIFT = 9;

  // Signed divide by 2^sh, truncating toward zero
  function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] x,
                                                    input int unsigned sh);
    logic signed [31:0] bias;
    bias = x[31] ? ((32'sd1 <<< sh) - 32'sd1) : 32'sd0;
    return (x + bias) >>> sh;
  endfunction

  // Q31 product, floor of a*b / 2^31, wrapped to 32 bits
  function automatic logic signed [31:0] q31_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p[62:31];
  endfunction

endpackage

// ===== rtl/core/clock_sync_pi_loop.sv =====
// Clock sync PLL with step detection, optional Q31 lowpass and PI loop filter.
// Path: an input transfer is held in the input register, then moves to the result
// register when the output is free; a stalled result holds it back.
// Throughput: one item per cycle while the output is not stalled, set by the state
// update through the two parallel Q31 multipliers of the lowpass.
// Reset: loop state clears to zero, registers take their defaults, no sweep.
`include "clock_sync_pi_loop_macros.svh"

module clock_sync_pi_loop import csp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic signed [31:0] offset_i,

  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic signed [31:0] freq_correction_o,
  output logic signed [31:0] phase_correction_o,
  output logic signed [31:0] phase_error_o,
  output logic signed [31:0] step_amount_o,
  output logic signed [31:0] filtered_offset_o,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // config registers
  logic [30:0]        step_limit_q;
  logic signed [31:0] filter_b_q, filter_a_q;
  logic               filter_en_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_limit_q <= STEP_LIMIT_RST;
      filter_b_q   <= FILTER_B_RST;
      filter_a_q   <= FILTER_A_RST;
      filter_en_q  <= FILTER_EN_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_STEP_LIMIT: step_limit_q <= pwdata[30:0];
        REG_FILTER_B:   filter_b_q   <= pwdata;
        REG_FILTER_A:   filter_a_q   <= pwdata;
        REG_FILTER_EN:  filter_en_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_STEP_LIMIT: prdata = {1'b0, step_limit_q};
      REG_FILTER_B:   prdata = filter_b_q;
      REG_FILTER_A:   prdata = filter_a_q;
      REG_FILTER_EN:  prdata = {31'd0, filter_en_q};
      default:        prdata = 32'd0;
    endcase
  end

  // input register and handshake
  logic               in_vld_q;
  logic               mode_q;
  logic signed [31:0] offset_q;
  logic               advance, fire;

  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = !in_vld_q || advance;
  assign fire       = in_vld_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q   <= mode_i;
      offset_q <= offset_i;
    end
  end

  // loop state
  logic signed [31:0] ref_q, ref_d;
  logic signed [31:0] loop_q, loop_d;
  logic signed [31:0] integ_q, integ_d;
  logic signed [31:0] fin_q, fin_d;
  logic signed [31:0] fout_q, fout_d;

  // result fields
  kind_e              kind_d, kind_q;
  logic signed [31:0] freq_d, phase_d, perr_d, step_d;

  logic signed [32:0] off_ext, lim_ext;
  logic               big;
  logic signed [31:0] lp_sum, lp_y;
  logic signed [31:0] ref_dec, err, e_p, ierr;

  assign off_ext = {offset_q[31], offset_q};
  assign lim_ext = {2'b00, step_limit_q};
  assign big     = (off_ext >= lim_ext) || (off_ext <= -lim_ext);

  assign lp_sum = offset_q + fin_q;
  assign lp_y   = q31_mul(filter_b_q, lp_sum) - q31_mul(filter_a_q, fout_q);

  assign ref_dec = ref_q - sdiv_pow2(ref_q, KD_SHIFT);
  assign err     = loop_q - ref_dec;
  assign e_p     = sdiv_pow2(err, KP_SHIFT);
  assign ierr    = integ_q + sdiv_pow2(e_p, KI_SHIFT);

  always_comb begin
    ref_d   = ref_q;
    loop_d  = loop_q;
    integ_d = integ_q;
    fin_d   = fin_q;
    fout_d  = fout_q;
    kind_d  = KIND_LOOP;
    freq_d  = 32'sd0;
    phase_d = 32'sd0;
    perr_d  = 32'sd0;
    step_d  = 32'sd0;
    if (mode_q == MODE_MEAS) begin
      if (big) begin
        kind_d = KIND_STEP;
        step_d = offset_q;
        loop_d = 32'sd0;
        ref_d  = 32'sd0;
      end else begin
        kind_d = KIND_OFFSET;
        if (filter_en_q) begin
          fin_d  = offset_q;
          fout_d = lp_y;
          loop_d = lp_y;
          ref_d  = lp_y;
        end else begin
          loop_d = offset_q;
          ref_d  = offset_q;
        end
      end
    end else begin
      ref_d   = ref_dec;
      integ_d = ierr;
      perr_d  = err;
      phase_d = e_p;
      freq_d  = ierr + e_p;
      loop_d  = loop_q - e_p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q   <= 32'sd0;
      loop_q  <= 32'sd0;
      integ_q <= 32'sd0;
      fin_q   <= 32'sd0;
      fout_q  <= 32'sd0;
    end else if (fire) begin
      ref_q   <= ref_d;
      loop_q  <= loop_d;
      integ_q <= integ_d;
      fin_q   <= fin_d;
      fout_q  <= fout_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      kind_q             <= kind_d;
      freq_correction_o  <= freq_d;
      phase_correction_o <= phase_d;
      phase_error_o      <= perr_d;
      step_amount_o      <= step_d;
      filtered_offset_o  <= loop_d;
    end
  end

  assign kind_o = kind_q;

  `CSP_ASSERT_IMP(a_step_fields, out_valid_o && kind_o == KIND_STEP, freq_correction_o == 0 && phase_correction_o == 0 && phase_error_o == 0 && filtered_offset_o == 0, "step result carries loop fields")
  `CSP_ASSERT_IMP(a_no_step_amount, out_valid_o && kind_o != KIND_STEP, step_amount_o == 0, "step amount outside a step result")
  `CSP_ASSERT_NEXT(a_stage_moves, in_vld_q && !out_valid_o, out_valid_o, "staged item not moved to result")
  `CSP_ASSERT_NEXT(a_out_drains, out_valid_o && out_ready_i && !in_vld_q, !out_valid_o, "result repeated after transfer")

endmodule

// ===== tb/clock_sync_pi_loop_checker.sv =====
// Result predictor and scoreboard for the clock sync PI loop.
`timescale 1ns / 100ps

module clock_sync_pi_loop_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        mode_i,
  input  logic [31:0] offset_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [31:0] freq_correction_i,
  input  logic [31:0] phase_correction_i,
  input  logic [31:0] phase_error_i,
  input  logic [31:0] step_amount_i,
  input  logic [31:0] filtered_offset_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fails_o,
  output int          pending_o
);
  import csp_pkg::*;

  localparam int DECAY_DIV   = 4;
  localparam int PROP_DIV    = 8;
  localparam int INTEG_DIV   = 512;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] freq;
    logic [31:0] phase;
    logic [31:0] perr;
    logic [31:0] step;
    logic [31:0] filt;
  } loop_result_t;

  logic [30:0] step_limit;
  int          coef_b;
  int          coef_a;
  logic        lowpass_on;

  int reference;
  int loop_offset;
  int last_error;
  int integrator;
  int lp_in_prev;
  int lp_out_prev;

  loop_result_t expected_q[$];

  // floor(a * b / 2^31), low 32 bits
  function automatic int q31_product(input int a, input int b);
    longint p;
    p = longint'(a) * longint'(b);
    return int'(p >>> 31);
  endfunction

  function automatic loop_result_t loop_update(input logic mode, input int offs);
    loop_result_t r;
    longint       lim;
    int           x;
    int           e;
    r = '0;
    if (mode == MODE_MEAS) begin
      lim = longint'(step_limit);
      if (longint'(offs) >= lim || longint'(offs) <= -lim) begin
        r.kind      = KIND_STEP;
        r.step      = offs;
        loop_offset = 0;
        reference   = 0;
      end else begin
        x = offs;
        if (lowpass_on) begin
          x           = q31_product(coef_b, offs + lp_in_prev) - q31_product(coef_a, lp_out_prev);
          lp_in_prev  = offs;
          lp_out_prev = x;
        end
        loop_offset = x;
        reference   = x;
        r.kind      = KIND_OFFSET;
      end
    end else begin
      reference   = reference - reference / DECAY_DIV;
      last_error  = loop_offset - reference;
      e           = last_error / PROP_DIV;
      integrator  = integrator + e / INTEG_DIV;
      r.kind      = KIND_LOOP;
      r.phase     = e;
      r.freq      = integrator + e;
      r.perr      = last_error;
      loop_offset = loop_offset - e;
    end
    r.filt = loop_offset;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fails_o++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name,
               $signed(want), $signed(got));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    loop_result_t want;
    if (!rst_ni) begin
      step_limit  = STEP_LIMIT_RST;
      coef_b      = FILTER_B_RST;
      coef_a      = FILTER_A_RST;
      lowpass_on  = FILTER_EN_RST;
      reference   = 0;
      loop_offset = 0;
      last_error  = 0;
      integrator  = 0;
      lp_in_prev  = 0;
      lp_out_prev = 0;
      fails_o     = 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_STEP_LIMIT: step_limit = pwdata[30:0];
          REG_FILTER_B:   coef_b     = pwdata;
          REG_FILTER_A:   coef_a     = pwdata;
          REG_FILTER_EN:  lowpass_on = pwdata[0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          fails_o++;
          $display("%0t: unexpected transfer, expected none, got kind %0d", $time, kind_i);
        end else begin
          want = expected_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind_i));
          check_field("freq_correction", want.freq, freq_correction_i);
          check_field("phase_correction", want.phase, phase_correction_i);
          check_field("phase_error", want.perr, phase_error_i);
          check_field("step_amount", want.step, step_amount_i);
          check_field("filtered_offset", want.filt, filtered_offset_i);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_q.push_back(loop_update(mode_i, offset_i));
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== tb/clock_sync_pi_loop_test.sv =====
// Top-level testbench for the clock sync PI loop: stimulus, config writes and verdict.
`timescale 1ns / 100ps

module clock_sync_pi_loop_test;
  import csp_pkg::*;

  localparam int N_PHASES       = 8;
  localparam int PHASE_ITEMS    = 179;
  localparam int MEAS_PERCENT   = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_PHASE     = 3;
  localparam int HOLD_ITEM      = 40;
  localparam int PAUSE_PHASE    = 2;
  localparam int PAUSE_ITEM     = 90;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 3000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic        in_mode;
  logic [31:0] in_offset;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [31:0] freq_correction;
  logic [31:0] phase_correction;
  logic [31:0] phase_error;
  logic [31:0] step_amount;
  logic [31:0] filtered_offset;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fails;
  int          pending;
  int          idle_cycles;
  int          burst_left;
  bit          hold_req;
  bit          hold_done;
  logic [30:0] cur_limit;

  clock_sync_pi_loop dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .mode_i             (in_mode),
    .offset_i           (in_offset),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .kind_o             (kind),
    .freq_correction_o  (freq_correction),
    .phase_correction_o (phase_correction),
    .phase_error_o      (phase_error),
    .step_amount_o      (step_amount),
    .filtered_offset_o  (filtered_offset),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  clock_sync_pi_loop_checker checker_i (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .mode_i             (in_mode),
    .offset_i           (in_offset),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .kind_i             (kind),
    .freq_correction_i  (freq_correction),
    .phase_correction_i (phase_correction),
    .phase_error_i      (phase_error),
    .step_amount_i      (step_amount),
    .filtered_offset_i  (filtered_offset),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .pready             (pready),
    .fails_o            (fails),
    .pending_o          (pending)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // no transfer of any kind for too long means the block hung
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: segments of varying stall density, plus one long hold-off on request
  initial begin : receiver
    int unsigned seg;
    int unsigned stall_pct;
    out_ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      seg = $urandom_range(200, 20);
      case ($urandom_range(3, 0))
        0:       stall_pct = 0;
        1:       stall_pct = 10;
        2:       stall_pct = 40;
        default: stall_pct = 85;
      endcase
      repeat (seg) begin
        @(negedge clk_i);
        if (hold_req && !hold_done) begin
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk_i);
          hold_done = 1'b1;
        end else begin
          out_ready <= ($urandom_range(99, 0) >= stall_pct);
        end
      end
    end
  end

  task automatic send_item(input logic mode, input logic [31:0] offs);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(12, 1);
      if (gap > 0 && !(hold_req && !hold_done)) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_mode   <= mode;
    in_offset <= offs;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_phase_config(input int phase);
    logic [31:0] lim;
    logic [31:0] coef_b;
    logic [31:0] coef_a;
    logic [31:0] en_word;
    logic        en;
    lim    = $urandom();
    coef_b = $urandom();
    coef_a = $urandom();
    en     = 1'b1;
    case (phase)
      1: begin
        lim    = 32'hffff_ffff;
        coef_b = 32'h7fff_ffff;
        coef_a = 32'h8000_0000;
      end
      2: lim = 32'h0;
      3: begin
        lim    = 32'h0800_0000;
        coef_b = 32'h8000_0000;
        coef_a = 32'h7fff_ffff;
      end
      4: begin
        lim = 32'h4000_0000;
        en  = 1'b0;
      end
      5: begin
        coef_b = 32'h4000_0000;
        coef_a = 32'hc000_0000;
      end
      6: begin
        lim    = 32'h0100_0000;
        coef_b = 32'h1000_0000;
        coef_a = 32'h7000_0000;
      end
      default: begin
        lim    = 32'h7fff_ffff;
        coef_b = 32'h0;
        coef_a = 32'h0;
        en     = 1'b0;
      end
    endcase
    en_word    = $urandom();
    en_word[0] = en;
    write_reg(REG_STEP_LIMIT, lim);
    write_reg(REG_FILTER_B, coef_b);
    write_reg(REG_FILTER_A, coef_a);
    write_reg(REG_FILTER_EN, en_word);
    cur_limit = lim[30:0];
  endtask

  function automatic logic [31:0] pick_offset();
    logic [31:0]  mag;
    int unsigned  sel;
    sel = $urandom_range(9, 0);
    if (sel < 5)
      mag = (cur_limit > 1) ? $urandom_range(cur_limit - 1, 0) : 32'h0;
    else if (sel == 5)
      mag = 32'(cur_limit) - $urandom_range(1, 0);
    else if (sel < 8)
      return $urandom();
    else
      mag = $urandom_range(4095, 0);
    return $urandom_range(1, 0) ? -mag : mag;
  endfunction

  initial begin : stimulus
    logic mode;
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_mode    = MODE_TICK;
    in_offset  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    hold_req   = 1'b0;
    burst_left = 0;
    cur_limit  = STEP_LIMIT_RST;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset defaults: step limit boundaries, full-scale offsets, ticks on fresh state
    send_item(MODE_TICK, $urandom());
    send_item(MODE_MEAS, 32'd1000);
    send_item(MODE_TICK, $urandom());
    send_item(MODE_TICK, $urandom());
    send_item(MODE_MEAS, 32'hf800_0001);
    send_item(MODE_TICK, $urandom());
    send_item(MODE_MEAS, 32'h07ff_ffff);
    send_item(MODE_MEAS, 32'h0800_0000);
    send_item(MODE_MEAS, 32'hf800_0000);
    send_item(MODE_TICK, $urandom());
    send_item(MODE_MEAS, 32'h7fff_ffff);
    send_item(MODE_MEAS, 32'h8000_0000);
    send_item(MODE_MEAS, 32'h0);
    send_item(MODE_TICK, $urandom());
    send_item(MODE_MEAS, 32'hffff_ffff);
    send_item(MODE_TICK, $urandom());
    send_item(MODE_TICK, $urandom());

    for (int phase = 0; phase < N_PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        set_phase_config(phase);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == HOLD_PHASE && i == HOLD_ITEM)
          hold_req = 1'b1;
        if (phase == PAUSE_PHASE && i == PAUSE_ITEM)
          drain();
        mode = ($urandom_range(99, 0) < MEAS_PERCENT) ? MODE_MEAS : MODE_TICK;
        send_item(mode, pick_offset());
      end
    end

    drain();
    if (fails == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== clock_sync_pi_loop.f =====
+incdir+rtl/core
rtl/core/csp_pkg.sv
rtl/core/clock_sync_pi_loop.sv
tb/clock_sync_pi_loop_checker.sv
tb/clock_sync_pi_loop_test.sv
